// File: hw/rtl/tsq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the tick sleep queue.
// Used by tsq_ctrl, tsq_dp and tick_sleep_queue; depends on nothing.
package tsq_pkg;

	localparam int SLOTS_DEF = 32;
	localparam int TICK_W    = 32;
	localparam int ID_W      = 8;
	localparam int DELAY_W   = 16;

	localparam logic FUNC_SLEEP = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	typedef enum logic [1:0] {
		KIND_WOKEN   = 2'd0,
		KIND_VERDICT = 2'd1,
		KIND_SLEPT   = 2'd2,
		KIND_FULL    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ACT_NOTHING = 2'd0,
		ACT_YIELD   = 2'd1,
		ACT_DISABLE = 2'd2
	} action_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic sleep_go;
		logic tick_go;
		logic rd_en;
		logic rd_next;
		logic step;
		logic verdict;
	} tsq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;
		logic empty;
		logic last_entry;
		logic expired;
	} tsq_status_t;

endpackage

// File: hw/rtl/tsq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the tick sleep queue: accepts items and sequences the table scan.
// Depends on tsq_pkg.
module tsq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  func,
	output logic                  in_ready,
	input  tsq_pkg::tsq_status_t  status,
	output tsq_pkg::tsq_cmd_t     cmd
);
	import tsq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_VERDICT
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// A sleep item answers at once, so the output register must be free.
				in_ready = status.slot_free;
				if (in_valid && status.slot_free) begin
					if (func == FUNC_TICK) begin
						cmd.tick_go = 1'b1;
						state_d     = ST_SCAN;
					end else begin
						cmd.sleep_go = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (status.empty) begin
					state_d = ST_VERDICT;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// A kept entry moves on freely; an expired one waits for the output.
				if (!status.expired || status.slot_free) begin
					cmd.step = 1'b1;
					if (status.last_entry) begin
						state_d = ST_VERDICT;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_next = 1'b1;
					end
				end
			end
			ST_VERDICT: begin
				if (status.slot_free) begin
					cmd.verdict = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/tsq_dp.sv
`timescale 1ns / 1ps
// Datapath of the tick sleep queue: tick counter, slot memory, scan pointers
// and the output register. Depends on tsq_pkg.
module tsq_dp #(
	parameter int SLOTS = tsq_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsq_pkg::tsq_cmd_t             cmd,
	output tsq_pkg::tsq_status_t          status,
	input  logic [tsq_pkg::ID_W-1:0]      thread_id,
	input  logic [tsq_pkg::DELAY_W-1:0]   delay,
	input  logic                          cpu_idle,
	input  logic                          future_pending,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    kind,
	output logic [tsq_pkg::ID_W-1:0]      woken_id,
	output logic [1:0]                    action,
	output logic                          last
);
	import tsq_pkg::*;

	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef struct packed {
		logic [ID_W-1:0]   thread;
		logic [TICK_W-1:0] wake;
	} slot_t;

	slot_t              slot_mem [SLOTS];
	slot_t              rd_s1;
	slot_t              wr_data;
	logic [TICK_W-1:0]  tick_q;
	logic [CNT_W-1:0]   entry_count_q;
	logic [CNT_W-1:0]   scan_i_q;
	logic [CNT_W-1:0]   scan_w_q;
	logic               woke_q;
	logic               idle_q;
	logic               fut_q;
	logic               out_valid_q;
	logic [1:0]         kind_q;
	logic [ID_W-1:0]    woken_id_q;
	logic [1:0]         action_q;
	logic               last_q;

	logic               full;
	logic               expired;
	logic [TICK_W-1:0]  diff;
	logic [CNT_W-1:0]   next_i;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   wr_addr;
	logic               wr_en;
	logic               out_load;
	logic [1:0]         verdict_action;

	assign full    = entry_count_q >= CNT_W'(SLOTS);
	// Wrap-safe compare: the entry is due when tick minus wake time is not negative.
	assign diff    = tick_q - rd_s1.wake;
	assign expired = ~diff[TICK_W-1];
	assign next_i  = scan_i_q + CNT_W'(1);

	assign status.slot_free  = ~out_valid_q | out_ready;
	assign status.empty      = entry_count_q == '0;
	assign status.last_entry = next_i == entry_count_q;
	assign status.expired    = expired;

	assign rd_addr = cmd.rd_next ? next_i[IDX_W-1:0] : '0;

	// Surviving entries are compacted towards the front; the write pointer never
	// passes the read pointer, so reads see entries not yet moved.
	assign wr_en   = (cmd.sleep_go & ~full) | (cmd.step & ~expired);
	assign wr_addr = cmd.sleep_go ? entry_count_q[IDX_W-1:0] : scan_w_q[IDX_W-1:0];
	always_comb begin
		if (cmd.sleep_go) begin
			wr_data.thread = thread_id;
			wr_data.wake   = tick_q + TICK_W'(delay);
		end else begin
			wr_data = rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_s1 <= slot_mem[rd_addr];
		end
	end

	assign out_load = cmd.sleep_go | (cmd.step & expired) | cmd.verdict;

	always_comb begin
		if (idle_q && !woke_q && scan_w_q == '0) begin
			verdict_action = fut_q ? ACT_NOTHING : ACT_DISABLE;
		end else begin
			verdict_action = ACT_YIELD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			entry_count_q <= '0;
			scan_i_q      <= '0;
			scan_w_q      <= '0;
			woke_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.tick_go) begin
				tick_q   <= tick_q + TICK_W'(1);
				scan_i_q <= '0;
				scan_w_q <= '0;
				woke_q   <= 1'b0;
			end
			if (cmd.sleep_go && !full) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
			end
			if (cmd.step) begin
				scan_i_q <= next_i;
				if (expired) begin
					woke_q <= 1'b1;
				end else begin
					scan_w_q <= scan_w_q + CNT_W'(1);
				end
			end
			if (cmd.verdict) begin
				entry_count_q <= scan_w_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_go) begin
			idle_q <= cpu_idle;
			fut_q  <= future_pending;
		end
		if (out_load) begin
			if (cmd.sleep_go) begin
				kind_q     <= full ? KIND_FULL : KIND_SLEPT;
				woken_id_q <= '0;
				action_q   <= ACT_NOTHING;
				last_q     <= 1'b1;
			end else if (cmd.verdict) begin
				kind_q     <= KIND_VERDICT;
				woken_id_q <= '0;
				action_q   <= verdict_action;
				last_q     <= 1'b1;
			end else begin
				kind_q     <= KIND_WOKEN;
				woken_id_q <= rd_s1.thread;
				action_q   <= ACT_NOTHING;
				last_q     <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign woken_id  = woken_id_q;
	assign action    = action_q;
	assign last      = last_q;

endmodule

// File: hw/rtl/tick_sleep_queue.sv
`timescale 1ns / 1ps
// Tick sleep queue: a 32-bit tick counter and an insertion-ordered table of
// sleeping threads. Input items are sleep requests (func 0) or timer ticks
// (func 1), taken on in_valid and in_ready. Results leave on out_valid and
// out_ready, one item per handshake, with last set on the final result of
// each input item.
// A sleep item gives one result (accepted or table full) in the cycle after
// it is taken and the block is ready again at once when the output is free.
// A tick item scans the table through one memory read port, one entry per
// cycle while the output is not stalled: it gives the woken threads in order,
// then a verdict.
// A stall on the output holds the scan at the next expired entry or at the
// verdict; the result register itself stays loaded until it is taken.
// Reset clears the tick counter, empties the table and drops any result held;
// the table memory needs no clearing pass.
// Depends on tsq_pkg, tsq_ctrl and tsq_dp.
module tick_sleep_queue #(
	parameter int SLOTS = tsq_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [tsq_pkg::ID_W-1:0]      thread_id,
	input  logic [tsq_pkg::DELAY_W-1:0]   delay,
	input  logic                          cpu_idle,
	input  logic                          future_pending,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    kind,
	output logic [tsq_pkg::ID_W-1:0]      woken_id,
	output logic [1:0]                    action,
	output logic                          last
);
	import tsq_pkg::*;

	tsq_cmd_t    cmd;
	tsq_status_t status;

	tsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tsq_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.thread_id      (thread_id),
		.delay          (delay),
		.cpu_idle       (cpu_idle),
		.future_pending (future_pending),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.woken_id       (woken_id),
		.action         (action),
		.last           (last)
	);

`ifndef ASSERT_OFF
	a_sleep_answer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_SLEEP |=>
		out_valid && last && (kind == KIND_SLEPT || kind == KIND_FULL))
		else $error("sleep item not answered in the next cycle");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind != KIND_WOKEN)))
		else $error("last flag does not match result kind");

	a_action_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_VERDICT |-> action == ACT_NOTHING)
		else $error("action set on a result that is not a verdict");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step || cmd.verdict |-> !in_ready)
		else $error("input taken while a tick is being processed");
`endif

endmodule
